[design/clfw_pkg.sv]
`timescale 1ns / 1ps

package clfw_pkg;

    localparam int MAX_FRAME_LEN = 1536;
    localparam int FIELD_LEN_W   = 11;
    localparam int CAP_W         = $clog2(MAX_FRAME_LEN + 1);
    // captured length is never narrower than the reported field
    localparam int LEN_W         = (CAP_W > FIELD_LEN_W) ? CAP_W : FIELD_LEN_W;
    localparam int LEN_FIELD_MAX = (1 << FIELD_LEN_W) - 1;

    localparam logic [7:0]  OPEN_BYTE   = 8'h7B;
    localparam logic [7:0]  LF_BYTE     = 8'd10;
    localparam logic [7:0]  CR_BYTE     = 8'd13;
    localparam int          SHORT_LIMIT = 6;
    localparam logic [15:0] WATCH_RESET = 16'd90;
    localparam logic [15:0] WAIT_RESET  = 16'd10;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECHO_ENABLE = 2'd0,
        CFG_IDLE_RELOAD = 2'd1,
        CFG_MAX_WAIT    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } frame_status_t;

    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic                   byte_valid;
        logic [7:0]             out_byte;
        logic                   echo_valid;
        logic [FIELD_LEN_W-1:0] frame_length;
        logic [1:0]             frame_status;
        logic                   waiting_message;
        logic                   reboot_request;
    } out_t;

    typedef struct packed {
        logic                   byte_valid;
        logic [7:0]             out_byte;
        logic                   echo_valid;
        logic [FIELD_LEN_W-1:0] frame_length;
        logic [1:0]             frame_status;
        logic                   term_seen;
    } fr_res_t;

    typedef struct packed {
        logic waiting_message;
        logic reboot_request;
    } wd_res_t;

endpackage

[design/clfw_framer.sv]
`timescale 1ns / 1ps

module clfw_framer
    import clfw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  in_t     item,
    input  logic    echo_enable,
    output fr_res_t res
);

    logic             capturing_reg, capturing_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic             hit, term, ovf;
    logic [LEN_W-1:0] len_inc;

    always_comb begin
        hit     = (item.func == FUNC_BYTE) && (capturing_reg || item.rx_byte == OPEN_BYTE);
        term    = (item.rx_byte == LF_BYTE) || (item.rx_byte == CR_BYTE);
        len_inc = length_reg + LEN_W'(1);
        ovf     = !term && (len_inc >= LEN_W'(MAX_FRAME_LEN));

        res = '0;
        if (hit) begin
            res.byte_valid   = 1'b1;
            res.out_byte     = item.rx_byte;
            res.echo_valid   = echo_enable;
            res.frame_length = (len_inc > LEN_W'(LEN_FIELD_MAX))
                             ? FIELD_LEN_W'(LEN_FIELD_MAX) : len_inc[FIELD_LEN_W-1:0];
            if (term) begin
                res.term_seen    = 1'b1;
                res.frame_status = (len_inc > LEN_W'(SHORT_LIMIT)) ? ST_COMPLETE : ST_SHORT;
            end else if (ovf) begin
                res.frame_status = ST_OVERFLOW;
            end
        end

        capturing_next = capturing_reg;
        length_next    = length_reg;
        if (fire && hit) begin
            capturing_next = !(term || ovf);
            length_next    = (term || ovf) ? '0 : len_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg <= 1'b0;
            length_reg    <= '0;
        end else begin
            capturing_reg <= capturing_next;
            length_reg    <= length_next;
        end
    end

endmodule

[design/clfw_watchdog.sv]
`timescale 1ns / 1ps

module clfw_watchdog
    import clfw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic        tick,
    input  logic        term_seen,
    input  logic [15:0] idle_reload,
    input  logic [15:0] max_wait,
    output wd_res_t     res
);

    logic        seen_reg, seen_next;
    logic [15:0] secs_reg, secs_next;
    logic [15:0] msgs_reg, msgs_next;

    always_comb begin
        res       = '0;
        seen_next = seen_reg;
        secs_next = secs_reg;
        msgs_next = msgs_reg;

        if (tick && idle_reload != 16'd0) begin
            priority if (seen_reg) begin
                // a frame terminator arrived since last tick: start a fresh silence window
                seen_next = 1'b0;
                msgs_next = '0;
                secs_next = idle_reload;
            end else if (secs_reg != 16'd0) begin
                secs_next = secs_reg - 16'd1;
            end else if (msgs_reg < max_wait) begin
                res.waiting_message = 1'b1;
                msgs_next           = msgs_reg + 16'd1;
            end else begin
                res.reboot_request = 1'b1;
            end
        end

        if (!tick && term_seen) begin
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
            secs_reg <= WATCH_RESET;
            msgs_reg <= '0;
        end else if (fire) begin
            seen_reg <= seen_next;
            secs_reg <= secs_next;
            msgs_reg <= msgs_next;
        end
    end

endmodule

[design/command_line_framer_with_idle_watchdog.sv]
// Command-line framer with idle watchdog.
// s_ channel: one request per byte (func 0) or one-second tick (func 1),
// valid/ready handshake. m_ channel: exactly one result per request, in order.
// cfg_ channel: register writes (0 echo enable, 1 idle reload seconds,
// 2 max waiting messages); cfg_ready is always high, write only while idle.
// Each taken request's result is registered in the result buffer.
// Throughput: one request per clock while s_ready is high, set by the
// single framer/watchdog update and the result register behind it.
// A two-entry result buffer sits in front of m_: when the receiver stalls,
// one more request is still taken and parked; s_ready then drops until the
// receiver takes a result.
// Reset (aresetn low, synchronous): framer idle with length 0, watchdog
// reloaded to 90 seconds with no messages sent, echo off, reload 90,
// max messages 10, result buffer empty.
`timescale 1ns / 1ps

module command_line_framer_with_idle_watchdog
    import clfw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic        echo_reg;
    logic [15:0] reload_reg;
    logic [15:0] max_wait_reg;

    logic        fire, take, tick;
    fr_res_t     fr_res;
    wd_res_t     wd_res;
    out_t        new_res;

    logic        out_valid_reg, skid_valid_reg;
    out_t        out_reg, skid_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign fire      = s_valid && s_ready;
    assign take      = out_valid_reg && m_ready;
    assign tick      = (s_data.func == FUNC_TICK);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_reg     <= 1'b0;
            reload_reg   <= WATCH_RESET;
            max_wait_reg <= WAIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ECHO_ENABLE: echo_reg     <= cfg_data[0];
                CFG_IDLE_RELOAD: reload_reg   <= cfg_data;
                CFG_MAX_WAIT:    max_wait_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    clfw_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (s_data),
        .echo_enable (echo_reg),
        .res         (fr_res)
    );

    clfw_watchdog u_watchdog (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .tick        (tick),
        .term_seen   (fr_res.term_seen),
        .idle_reload (reload_reg),
        .max_wait    (max_wait_reg),
        .res         (wd_res)
    );

    always_comb begin
        new_res.byte_valid      = fr_res.byte_valid;
        new_res.out_byte        = fr_res.out_byte;
        new_res.echo_valid      = fr_res.echo_valid;
        new_res.frame_length    = fr_res.frame_length;
        new_res.frame_status    = fr_res.frame_status;
        new_res.waiting_message = wd_res.waiting_message;
        new_res.reboot_request  = wd_res.reboot_request;
    end

    // control of the two-entry result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= fire;
            end
        end else if (fire) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (fire) begin
                out_reg <= new_res;
            end
        end else if (fire) begin
            if (out_valid_reg) begin
                skid_reg <= new_res;
            end else begin
                out_reg <= new_res;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("parked result without head result");

    a_echo_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.echo_valid |-> m_data.byte_valid)
        else $error("echo flagged on uncaptured byte");

    a_byte_or_watchdog: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.byte_valid |-> !m_data.waiting_message && !m_data.reboot_request)
        else $error("byte result carries watchdog flags");

    a_status_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_status != ST_NONE |-> m_data.byte_valid)
        else $error("frame status without captured byte");

    a_result_follows_request: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !out_valid_reg |=> out_valid_reg)
        else $error("accepted request produced no result");
`endif

endmodule

[test/command_line_framer_with_idle_watchdog_test.sv]
`timescale 1ns / 1ps

module command_line_framer_with_idle_watchdog_test;
    import clfw_pkg::*;

    localparam int STALL_LIMIT = 2000;

    class framer_scoreboard;
        logic        echo_on;
        logic [15:0] reload_secs;
        logic [15:0] max_msgs;
        logic        in_frame;
        int unsigned frame_len;
        logic        seen_input;
        logic [15:0] secs_left;
        logic [15:0] msgs_sent;
        out_t        pending_results[$];
        int unsigned mismatches;
        int unsigned handled_items;
        int unsigned results_seen;

        function new();
            echo_on       = 1'b0;
            reload_secs   = WATCH_RESET;
            max_msgs      = WAIT_RESET;
            in_frame      = 1'b0;
            frame_len     = 0;
            seen_input    = 1'b0;
            secs_left     = WATCH_RESET;
            msgs_sent     = '0;
            mismatches    = 0;
            handled_items = 0;
            results_seen  = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [15:0] value);
            case (idx)
                CFG_ECHO_ENABLE: echo_on = value[0];
                CFG_IDLE_RELOAD: reload_secs = value;
                CFG_MAX_WAIT:    max_msgs = value;
                default: ;
            endcase
        endfunction

        // works out the result of one accepted request and queues it
        function void note_request(in_t req);
            out_t res;
            res = '0;
            if (func_t'(req.func) == FUNC_BYTE) begin
                if (in_frame || req.rx_byte == OPEN_BYTE) begin
                    in_frame = 1'b1;
                    frame_len++;
                    handled_items++;
                    res.byte_valid = 1'b1;
                    res.out_byte = req.rx_byte;
                    res.echo_valid = echo_on;
                    res.frame_length = (frame_len > LEN_FIELD_MAX) ?
                        FIELD_LEN_W'(LEN_FIELD_MAX) : FIELD_LEN_W'(frame_len);
                    if (req.rx_byte == LF_BYTE || req.rx_byte == CR_BYTE) begin
                        seen_input = 1'b1;
                        res.frame_status = (frame_len > SHORT_LIMIT) ? ST_COMPLETE : ST_SHORT;
                        in_frame = 1'b0;
                        frame_len = 0;
                    end else if (frame_len >= MAX_FRAME_LEN) begin
                        res.frame_status = ST_OVERFLOW;
                        in_frame = 1'b0;
                        frame_len = 0;
                    end
                end
            end else begin
                handled_items++;
                if (reload_secs != 0) begin
                    if (seen_input) begin
                        msgs_sent = '0;
                        seen_input = 1'b0;
                        secs_left = reload_secs;
                    end else if (secs_left != 0) begin
                        secs_left--;
                    end else if (msgs_sent < max_msgs) begin
                        res.waiting_message = 1'b1;
                        msgs_sent++;
                    end else begin
                        res.reboot_request = 1'b1;
                    end
                end
            end
            pending_results.push_back(res);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("mismatch: %s", what);
        endtask

        task check_field(string name, logic [10:0] got, logic [10:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                    want));
        endtask

        task check_result(out_t got);
            out_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with no request pending", results_seen));
                return;
            end
            want = pending_results.pop_front();
            check_field("byte_valid", got.byte_valid, want.byte_valid);
            check_field("out_byte", got.out_byte, want.out_byte);
            check_field("echo_valid", got.echo_valid, want.echo_valid);
            check_field("frame_length", got.frame_length, want.frame_length);
            check_field("frame_status", got.frame_status, want.frame_status);
            check_field("waiting_message", got.waiting_message, want.waiting_message);
            check_field("reboot_request", got.reboot_request, want.reboot_request);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    framer_scoreboard sb = new();
    int unsigned stall_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned ready_hold = 0;
    int unsigned ready_pick;

    command_line_framer_with_idle_watchdog dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: short stalls, a few long ones, and long stretches always ready
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 10) begin
                m_ready <= 1'b1;
                ready_hold <= $urandom_range(100, 300);
            end else if (ready_pick < 55) begin
                m_ready <= 1'b1;
                ready_hold <= $urandom_range(0, 5);
            end else if (ready_pick < 95) begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(10, 60);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
        if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned next_gap();
        int unsigned pick;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            burst_left = $urandom_range(40, 150);
            return 0;
        end
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(in_t req);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        gap = next_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_byte(logic [7:0] value);
        in_t req;
        req.func = FUNC_BYTE;
        req.rx_byte = value;
        send_request(req);
    endtask

    task automatic send_tick();
        in_t req;
        req.func = FUNC_TICK;
        req.rx_byte = 8'($urandom_range(0, 255));
        send_request(req);
    endtask

    // opening brace, n payload bytes free of terminators, then CR or LF if asked
    task automatic send_frame(int unsigned n, bit terminated);
        logic [7:0] value;
        send_byte(OPEN_BYTE);
        repeat (n) begin
            do value = 8'($urandom_range(0, 255));
            while (value == LF_BYTE || value == CR_BYTE);
            send_byte(value);
        end
        if (terminated)
            send_byte($urandom_range(0, 1) ? CR_BYTE : LF_BYTE);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_registers(logic echo, logic [15:0] reload, logic [15:0] max_wait);
        write_register(CFG_ECHO_ENABLE, {15'($urandom_range(0, 32767)), echo});
        write_register(CFG_IDLE_RELOAD, reload);
        write_register(CFG_MAX_WAIT, max_wait);
    endtask

    task automatic run_traffic(int unsigned target);
        int unsigned start_count;
        int unsigned pick;
        int unsigned n;
        start_count = sb.handled_items;
        while (sb.handled_items - start_count < target) begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
            if (pick < 50) begin
                send_frame(n, 1'b1);
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 8)) send_tick();
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                // broken frame, whatever follows lands inside it
                send_frame(n, 1'b0);
            end else if (pick < 98) begin
                send_byte($urandom_range(0, 1) ? CR_BYTE : LF_BYTE);
            end else begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bytes outside a frame are dropped
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(OPEN_BYTE);
        send_byte(CR_BYTE);
        // length of exactly six is still too short
        send_byte(OPEN_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(OPEN_BYTE);
        send_byte(8'h62);
        send_byte(LF_BYTE);
        send_frame(5, 1'b1);
        send_tick();
        send_tick();
        wait_for_results();

        // watchdog runs out quickly: reload, count down, two waits, then reboots
        program_registers(1'b1, 16'd1, 16'd2);
        send_frame(0, 1'b1);
        repeat (7) send_tick();
        // ticks in the middle of a frame
        send_byte(OPEN_BYTE);
        send_tick();
        send_byte(8'h7E);
        send_tick();
        send_byte(CR_BYTE);
        // frame that hits the size limit, then one terminated right at it
        send_frame(MAX_FRAME_LEN - 1, 1'b0);
        send_frame(MAX_FRAME_LEN - 2, 1'b1);
        run_traffic(200);
        wait_for_results();

        program_registers(1'b0, 16'd0, 16'hFFFF);
        run_traffic(200);
        wait_for_results();

        program_registers(1'b1, 16'hFFFF, 16'd0);
        run_traffic(200);
        wait_for_results();

        program_registers(1'b0, 16'd2, 16'd3);
        run_traffic(200);
        wait_for_results();

        program_registers(1'b1, 16'd1, 16'd0);
        run_traffic(200);
        wait_for_results();

        program_registers(1'($urandom_range(0, 1)), 16'($urandom_range(1, 4)),
            16'($urandom_range(0, 5)));
        run_traffic(200);
        wait_for_results();

        repeat (5) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[command_line_framer_with_idle_watchdog.f]
design/clfw_pkg.sv
design/clfw_framer.sv
design/clfw_watchdog.sv
design/command_line_framer_with_idle_watchdog.sv
test/command_line_framer_with_idle_watchdog_test.sv
